### rtl/core/brfpd_pkg.sv
// Package for the byte ring FIFO with peek and discard.
// Holds the sizing constants, operation and status codes, sequencer states
// and the packed item types of both channels. Depends on nothing.
`default_nettype none

package brfpd_pkg;

    // Store sizing and burst limit.
    localparam int DEPTH     = 1024;
    localparam int IDX_W     = $clog2(DEPTH);
    localparam int CAP_W     = 11;
    localparam int MAX_BURST = 64;
    localparam int CNT_W     = $clog2(MAX_BURST + 1);

    // Operation codes carried by an input item.
    typedef enum logic [1:0] {
        OP_WRITE   = 2'd0,
        OP_READ    = 2'd1,
        OP_FETCH   = 2'd2,
        OP_DISCARD = 2'd3
    } t_op;

    // Status codes carried by a result item.
    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NOSPACE = 2'd1,
        ST_NODATA  = 2'd2,
        ST_TOOLONG = 2'd3
    } t_status;

    // Sequencer states.
    typedef enum logic {
        S_IDLE   = 1'b0,
        S_STREAM = 1'b1
    } t_state;

    // One input item.
    typedef struct packed {
        t_op              op;
        logic [CAP_W-1:0] length;
        logic [7:0]       data_in;
        logic             first;
    } t_in_item;

    // One result item.
    typedef struct packed {
        logic [7:0]       data_out;
        logic             has_data;
        t_status          status;
        logic             last;
        logic [CAP_W-1:0] occupied;
    } t_out_item;

endpackage

`default_nettype wire

### rtl/core/byte_ring_fifo_peek_discard_top.sv
// Top level of the byte ring FIFO with peek and discard: byte store,
// pointers, burst tracking and the read sequencer. Depends on brfpd_pkg.
//
// A result is registered and presented in the cycle after its item is accepted.
// Write, discard and rejected or empty requests give one result each; a read or
// fetch streams its bytes out, one byte per cycle while the output is not stalled,
// from the store's single registered read port, before the next item is taken.
// Reset (synchronous, active low) empties the FIFO and sets capacity to 1024.
`default_nettype none

module byte_ring_fifo_peek_discard_top (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_in_valid,
    output logic                              o_in_stall,
    input  wire brfpd_pkg::t_in_item          i_in_item,
    output logic                              o_out_valid,
    input  wire                               i_out_stall,
    output brfpd_pkg::t_out_item              o_out_item,
    input  wire                               i_cfg_valid,
    output logic                              o_cfg_ready,
    input  wire [brfpd_pkg::CAP_W-1:0]        i_cfg_data
);

    // Byte store and its registered read data.
    logic [7:0] mem [brfpd_pkg::DEPTH];
    logic [7:0] r_rdata;

    // Control state.
    brfpd_pkg::t_state            r_state, n_state;
    logic [brfpd_pkg::CAP_W-1:0]  r_cap, n_cap;
    logic [brfpd_pkg::IDX_W-1:0]  r_read_index, n_read_index;
    logic [brfpd_pkg::IDX_W-1:0]  r_write_index, n_write_index;
    logic [brfpd_pkg::CAP_W-1:0]  r_fill, n_fill;
    logic [brfpd_pkg::CAP_W-1:0]  r_burst_left, n_burst_left;
    logic                         r_burst_rej, n_burst_rej;
    logic [brfpd_pkg::CNT_W-1:0]  r_left, n_left;
    logic                         r_out_valid, n_out_valid;

    // Stream and result payload registers.
    logic [brfpd_pkg::IDX_W-1:0]  r_rd_ptr, n_rd_ptr;
    logic                         r_is_read, n_is_read;
    logic                         r_out_has_data, n_out_has_data;
    brfpd_pkg::t_status           r_out_status, n_out_status;
    logic                         r_out_last, n_out_last;
    logic [brfpd_pkg::CAP_W-1:0]  r_out_occ, n_out_occ;

    // Combinational controls.
    logic [brfpd_pkg::CAP_W-1:0]  cap_eff;
    logic [brfpd_pkg::CAP_W-1:0]  free_bytes;
    logic                         out_free;
    logic                         in_accept;
    logic                         cfg_we;
    logic                         mem_we;
    logic                         mem_re;
    logic [brfpd_pkg::IDX_W-1:0]  mem_raddr;
    logic                         start_stream;
    logic                         do_store;
    logic [brfpd_pkg::CAP_W-1:0]  req_n;
    logic [brfpd_pkg::CAP_W:0]    disc_sum;

    // Advance a ring index by one, wrapping at the capacity in use.
    function automatic logic [brfpd_pkg::IDX_W-1:0] ring_inc(
        input logic [brfpd_pkg::IDX_W-1:0] idx,
        input logic [brfpd_pkg::CAP_W-1:0] cap
    );
        logic [brfpd_pkg::CAP_W:0] sum;
        sum = (brfpd_pkg::CAP_W + 1)'(idx) + 1'b1;
        if (sum >= (brfpd_pkg::CAP_W + 1)'(cap)) begin
            return '0;
        end
        return brfpd_pkg::IDX_W'(sum);
    endfunction

    // Capacity in use: zero acts as one, oversize acts as the full store.
    always_comb begin
        if (r_cap == '0) begin
            cap_eff = brfpd_pkg::CAP_W'(1);
        end else if (r_cap > brfpd_pkg::CAP_W'(brfpd_pkg::DEPTH)) begin
            cap_eff = brfpd_pkg::CAP_W'(brfpd_pkg::DEPTH);
        end else begin
            cap_eff = r_cap;
        end
    end

    assign free_bytes = (r_fill >= cap_eff) ? '0 : cap_eff - r_fill;

    // Handshakes. The output slot is free when empty or being taken.
    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_in_stall  = !((r_state == brfpd_pkg::S_IDLE) && out_free);
    assign in_accept   = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;

    // Next state of the read sequencer.
    always_comb begin
        n_state = r_state;
        case (r_state)
            brfpd_pkg::S_IDLE: begin
                if (start_stream) begin
                    n_state = brfpd_pkg::S_STREAM;
                end
            end
            brfpd_pkg::S_STREAM: begin
                if (out_free && (r_left == brfpd_pkg::CNT_W'(1))) begin
                    n_state = brfpd_pkg::S_IDLE;
                end
            end
            default: n_state = brfpd_pkg::S_IDLE;
        endcase
    end

    // Datapath: operation decode, pointer updates and result loading.
    always_comb begin
        n_cap          = r_cap;
        n_read_index   = r_read_index;
        n_write_index  = r_write_index;
        n_fill         = r_fill;
        n_burst_left   = r_burst_left;
        n_burst_rej    = r_burst_rej;
        n_left         = r_left;
        n_rd_ptr       = r_rd_ptr;
        n_is_read      = r_is_read;
        n_out_valid    = r_out_valid && i_out_stall;
        n_out_has_data = r_out_has_data;
        n_out_status   = r_out_status;
        n_out_last     = r_out_last;
        n_out_occ      = r_out_occ;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        mem_raddr      = r_rd_ptr;
        start_stream   = 1'b0;
        do_store       = 1'b0;
        req_n          = '0;
        disc_sum       = '0;

        if (in_accept) begin
            // Every accepted item loads one result into the output slot.
            n_out_valid    = 1'b1;
            n_out_has_data = 1'b0;
            n_out_last     = 1'b1;
            n_out_status   = brfpd_pkg::ST_OK;
            case (i_in_item.op)
                brfpd_pkg::OP_WRITE: begin
                    // All-or-nothing bursts: the first item decides.
                    if (i_in_item.first) begin
                        n_burst_rej  = 1'b0;
                        n_burst_left = '0;
                        if (i_in_item.length == '0) begin
                            n_out_status = brfpd_pkg::ST_OK;
                        end else if (i_in_item.length > free_bytes) begin
                            n_burst_rej  = 1'b1;
                            n_burst_left = i_in_item.length - 1'b1;
                            n_out_status = brfpd_pkg::ST_NOSPACE;
                        end else begin
                            n_burst_left = i_in_item.length - 1'b1;
                            do_store     = 1'b1;
                        end
                    end else if (r_burst_left == '0) begin
                        n_out_status = brfpd_pkg::ST_NOSPACE;
                    end else begin
                        n_burst_left = r_burst_left - 1'b1;
                        if (r_burst_rej || (free_bytes == '0)) begin
                            n_out_status = brfpd_pkg::ST_NOSPACE;
                        end else begin
                            do_store = 1'b1;
                        end
                    end
                    if (do_store) begin
                        mem_we        = 1'b1;
                        n_write_index = ring_inc(r_write_index, cap_eff);
                        n_fill        = r_fill + 1'b1;
                    end
                end
                brfpd_pkg::OP_DISCARD: begin
                    // The sum stays below twice the capacity, so one subtract wraps it.
                    if (i_in_item.length > r_fill) begin
                        n_out_status = brfpd_pkg::ST_NODATA;
                    end else begin
                        disc_sum = (brfpd_pkg::CAP_W + 1)'(r_read_index)
                                 + (brfpd_pkg::CAP_W + 1)'(i_in_item.length);
                        if (disc_sum >= (brfpd_pkg::CAP_W + 1)'(cap_eff)) begin
                            disc_sum = disc_sum - (brfpd_pkg::CAP_W + 1)'(cap_eff);
                        end
                        n_read_index = brfpd_pkg::IDX_W'(disc_sum);
                        n_fill       = r_fill - i_in_item.length;
                    end
                end
                default: begin
                    // Read or fetch: the first byte is read from the store now.
                    if (i_in_item.length > brfpd_pkg::CAP_W'(brfpd_pkg::MAX_BURST)) begin
                        n_out_status = brfpd_pkg::ST_TOOLONG;
                    end else if (i_in_item.length == '0) begin
                        n_out_status = brfpd_pkg::ST_OK;
                    end else begin
                        if (i_in_item.op == brfpd_pkg::OP_READ) begin
                            req_n = (i_in_item.length < r_fill) ? i_in_item.length : r_fill;
                        end else begin
                            req_n = (i_in_item.length <= r_fill) ? i_in_item.length : '0;
                        end
                        if (req_n == '0) begin
                            n_out_status = brfpd_pkg::ST_NODATA;
                        end else begin
                            mem_re         = 1'b1;
                            mem_raddr      = r_read_index;
                            n_rd_ptr       = ring_inc(r_read_index, cap_eff);
                            n_out_has_data = 1'b1;
                            n_out_last     = (req_n == brfpd_pkg::CAP_W'(1));
                            n_left         = brfpd_pkg::CNT_W'(req_n - 1'b1);
                            n_is_read      = (i_in_item.op == brfpd_pkg::OP_READ);
                            start_stream   = (req_n != brfpd_pkg::CAP_W'(1));
                            if (i_in_item.op == brfpd_pkg::OP_READ) begin
                                n_fill = r_fill - req_n;
                                if (req_n == brfpd_pkg::CAP_W'(1)) begin
                                    n_read_index = n_rd_ptr;
                                end
                            end
                        end
                    end
                end
            endcase
            n_out_occ = n_fill;
        end else if ((r_state == brfpd_pkg::S_STREAM) && out_free) begin
            // Stream the following bytes, one read of the store per cycle while the output slot is free.
            mem_re         = 1'b1;
            mem_raddr      = r_rd_ptr;
            n_rd_ptr       = ring_inc(r_rd_ptr, cap_eff);
            n_left         = r_left - 1'b1;
            n_out_valid    = 1'b1;
            n_out_has_data = 1'b1;
            n_out_status   = brfpd_pkg::ST_OK;
            n_out_last     = (r_left == brfpd_pkg::CNT_W'(1));
            if ((r_left == brfpd_pkg::CNT_W'(1)) && r_is_read) begin
                n_read_index = n_rd_ptr;
            end
        end

        // A capacity write empties the FIFO.
        if (cfg_we) begin
            n_cap         = i_cfg_data;
            n_read_index  = '0;
            n_write_index = '0;
            n_fill        = '0;
            n_burst_left  = '0;
            n_burst_rej   = 1'b0;
        end
    end

    // Byte store. Reads and writes fall on different items, so no forwarding.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[r_write_index] <= i_in_item.data_in;
        end
        if (mem_re) begin
            r_rdata <= mem[mem_raddr];
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= brfpd_pkg::S_IDLE;
            r_cap         <= brfpd_pkg::CAP_W'(brfpd_pkg::DEPTH);
            r_read_index  <= '0;
            r_write_index <= '0;
            r_fill        <= '0;
            r_burst_left  <= '0;
            r_burst_rej   <= 1'b0;
            r_left        <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_cap         <= n_cap;
            r_read_index  <= n_read_index;
            r_write_index <= n_write_index;
            r_fill        <= n_fill;
            r_burst_left  <= n_burst_left;
            r_burst_rej   <= n_burst_rej;
            r_left        <= n_left;
            r_out_valid   <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_rd_ptr       <= n_rd_ptr;
        r_is_read      <= n_is_read;
        r_out_has_data <= n_out_has_data;
        r_out_status   <= n_out_status;
        r_out_last     <= n_out_last;
        r_out_occ      <= n_out_occ;
    end

    // Result item. A result without data shows a zero byte.
    always_comb begin
        o_out_valid         = r_out_valid;
        o_out_item.data_out = r_out_has_data ? r_rdata : 8'd0;
        o_out_item.has_data = r_out_has_data;
        o_out_item.status   = r_out_status;
        o_out_item.last     = r_out_last;
        o_out_item.occupied = r_out_occ;
    end

    // The fill level never exceeds the capacity in use.
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= cap_eff)
        else $error("fill level above capacity");

    // While streaming, a byte is always waiting in the output slot.
    a_stream_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == brfpd_pkg::S_STREAM) |-> r_out_valid)
        else $error("stream without a pending result");

    // The sequencer only streams while bytes remain.
    a_stream_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == brfpd_pkg::S_STREAM) |-> (r_left != '0))
        else $error("stream with no bytes left");

    // The fill level holds while a read or fetch streams out.
    a_fill_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == brfpd_pkg::S_STREAM) && !cfg_we) |=> $stable(r_fill))
        else $error("fill level changed during stream");

    // A store write and a store read never share a cycle.
    a_port_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(mem_we && mem_re))
        else $error("store read and write in one cycle");

endmodule

`default_nettype wire
